// ===== src/eca_pkg.sv =====
// ============================================================================
// eca_pkg: shared types and constants for the easing curve animator
// Holds the controller state encoding, datapath command bundle, curve codes
// and register address map.
// ============================================================================
package eca_pkg;

  localparam int FracBitsDefault = 16;
  localparam int ElapsedW        = 17;
  localparam int IntervalW       = 16;
  localparam int ValueW          = 32;
  localparam int CurveW          = 3;

  // Curve codes
  localparam logic [CurveW-1:0] CurveLinear = 3'd0;
  localparam logic [CurveW-1:0] CurveIn     = 3'd1;
  localparam logic [CurveW-1:0] CurveOut    = 3'd2;
  localparam logic [CurveW-1:0] CurveInOut  = 3'd3;
  localparam logic [CurveW-1:0] CurveBounce = 3'd4;

  // Register indexes (byte address / 4)
  localparam logic [1:0] RegBase  = 2'd0;
  localparam logic [1:0] RegIncr  = 2'd1;
  localparam logic [1:0] RegIntvl = 2'd2;
  localparam logic [1:0] RegCurve = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SHAPE,
    ST_SCALE,
    ST_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic start;     // load base, clear elapsed
    logic tick;      // accumulate elapsed, decide end
    logic div_step;  // one quotient bit
    logic shape;     // compute curve factor
    logic scale;     // value update
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic finished;  // tick ended animation
    logic hold;      // unknown curve
  } stat_t;

endpackage

// ===== src/easing_curve_animator.sv =====
// ============================================================================
// easing_curve_animator: tween evaluator top level
// APB register file, stream handshake and controller/datapath pairing.
// ============================================================================
// Sequence: start or idle tick goes to the result state in the next cycle; ending or
//   unknown-curve tick passes through the divide state first; evaluated tick runs
//   the one-bit-per-cycle phase divider, then the shape and scale steps.
// Throughput: one item at a time; next item taken the cycle after the result.
// Reset (rst, synchronous): idle, not running, value and delta zero,
//   registers base 0, increment 0, interval 1, curve linear.
module easing_curve_animator #(
  parameter int FRAC_BITS = eca_pkg::FracBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] delta_time
  input  logic        s_tuser,   // [0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [31:0] value, [63:32] delta_value
  output logic        m_tuser    // [0] running
);
  import eca_pkg::*;

  logic signed [ValueW-1:0] base_value, increment, value, delta_value;
  logic [IntervalW-1:0] interval;
  logic [CurveW-1:0]    curve;
  logic active, in_fire, out_fire;
  cmd_t  cmd;
  stat_t stat;

  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      base_value <= '0;
      increment  <= '0;
      interval   <= IntervalW'(1);
      curve      <= CurveLinear;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        RegBase:  base_value <= pwdata;
        RegIncr:  increment  <= pwdata;
        RegIntvl: interval   <= pwdata[IntervalW-1:0];
        RegCurve: curve      <= pwdata[CurveW-1:0];
        default:  ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[3:2])
      RegBase:  prdata = base_value;
      RegIncr:  prdata = increment;
      RegIntvl: prdata = 32'(interval);
      RegCurve: prdata = 32'(curve);
      default:  prdata = '0;
    endcase
  end

  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;

  eca_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_op(s_tuser), .active(active),
    .out_fire(out_fire), .stat(stat), .cmd(cmd), .in_ready(s_tready),
    .out_valid(m_tvalid)
  );

  eca_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .delta_time(s_tdata),
    .base_value(base_value), .increment(increment), .interval(interval),
    .curve(curve), .stat(stat), .value(value), .delta_value(delta_value),
    .active(active)
  );

  assign m_tdata = {delta_value, value};
  assign m_tuser = active;

endmodule

// ===== src/eca_ctrl.sv =====
// ============================================================================
// eca_ctrl: sequencing controller
// Accepts one item, walks the datapath through the divide, shape and scale
// steps that it needs, then presents the result beat until taken.
// ============================================================================
module eca_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_fire,
  input  logic          in_op,
  input  logic          active,
  input  logic          out_fire,
  input  eca_pkg::stat_t stat,
  output eca_pkg::cmd_t cmd,
  output logic          in_ready,
  output logic          out_valid
);
  import eca_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          if (in_op) begin
            cmd.start  = 1'b1;
            state_next = ST_DONE;
          end else begin
            // idle tick leaves all state alone
            cmd.tick   = active;
            state_next = active ? ST_DIV : ST_DONE;
          end
        end
      end
      ST_DIV: begin
        if (stat.finished || stat.hold) begin
          state_next = ST_DONE;
        end else if (stat.div_done) begin
          state_next = ST_SHAPE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_SHAPE: begin
        cmd.shape  = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_fire) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output is only offered after a finished sequence
  a_valid_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == ST_DONE) else $error("valid outside done");
  a_shape_scale: assert property (@(posedge clk) disable iff (rst)
    state == ST_SHAPE |=> state == ST_SCALE) else $error("shape not followed by scale");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready) else $error("accepted while busy");

endmodule

// ===== src/eca_dp.sv =====
// ============================================================================
// eca_dp: tween datapath
// Elapsed-time accumulator, restoring phase divider, curve shaping and
// value scaling registers.
// ============================================================================
module eca_dp #(
  parameter int FRAC_BITS = eca_pkg::FracBitsDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  input  eca_pkg::cmd_t                   cmd,
  input  logic [eca_pkg::IntervalW-1:0]   delta_time,
  input  logic signed [eca_pkg::ValueW-1:0] base_value,
  input  logic signed [eca_pkg::ValueW-1:0] increment,
  input  logic [eca_pkg::IntervalW-1:0]   interval,
  input  logic [eca_pkg::CurveW-1:0]      curve,
  output eca_pkg::stat_t                  stat,
  output logic signed [eca_pkg::ValueW-1:0] value,
  output logic signed [eca_pkg::ValueW-1:0] delta_value,
  output logic                            active
);
  import eca_pkg::*;

  localparam int NumW  = ElapsedW + FRAC_BITS;      // dividend width
  localparam int PW    = FRAC_BITS + 2;             // phase width, holds up to 2*ONE
  localparam int CntW  = $clog2(NumW + 1);
  localparam int BqW   = PW + 5;                    // 11*p and doubled
  localparam int MulW  = 2 * PW;
  localparam int BmW   = 2 * BqW;                   // bounce square
  localparam logic [PW-1:0] One = PW'(1) << FRAC_BITS;
  localparam logic [PW-1:0] Two = PW'(2) << FRAC_BITS;
  localparam logic [BqW-1:0] OneQ = BqW'(1) << FRAC_BITS;

  logic [ElapsedW-1:0] elapsed;
  logic [NumW-1:0]     quo;
  logic [IntervalW:0]  rem;
  logic [CntW-1:0]     cnt;
  logic                finished, hold;
  logic [FRAC_BITS:0]  factor;
  logic signed [ValueW-1:0] cur, ldelta;

  // Elapsed accumulation with saturation
  logic [ElapsedW:0] el_sum;
  logic              past_end;
  assign el_sum   = {1'b0, elapsed} + (ElapsedW+1)'(delta_time);
  logic [ElapsedW-1:0] el_new;
  assign el_new   = el_sum[ElapsedW] ? {ElapsedW{1'b1}} : el_sum[ElapsedW-1:0];
  assign past_end = el_new > ElapsedW'(interval);

  // Restoring divider step
  logic [IntervalW+1:0] trial;
  assign trial = {rem, quo[NumW-1]} - (IntervalW+2)'(interval);

  // Phase from the low quotient bits, ONE for a zero interval (quotient is at most ONE when valid)
  logic [PW-1:0] p;
  assign p = (interval == '0) ? One : quo[PW-1:0];

  // Curve factor
  logic [MulW-1:0] m_in, m_out, m_io1, m_io2;
  logic [BmW-1:0]  m_b;
  logic [PW-1:0]   u;
  logic [BqW-1:0]  q, q2, k2, c, mag;
  logic [FRAC_BITS+1:0] f_comb;
  always_comb begin
    u     = (p << 1) - One;
    m_in  = MulW'(p) * MulW'(p);
    m_out = MulW'(p) * MulW'(Two - p);
    m_io1 = MulW'(p) * MulW'(p) << 1;
    m_io2 = MulW'(u) * MulW'(Two - u);
    q     = BqW'(p) * BqW'(11);
    q2    = q << 1;
    if (q < BqW'(4) * OneQ) begin
      k2 = '0; c = '0;
    end else if (q < BqW'(8) * OneQ) begin
      k2 = BqW'(12) * OneQ; c = (BqW'(3) * OneQ) >> 2;
    end else if (q < BqW'(10) * OneQ) begin
      k2 = BqW'(18) * OneQ; c = (BqW'(15) * OneQ) >> 4;
    end else begin
      k2 = BqW'(21) * OneQ; c = (BqW'(63) * OneQ) >> 6;
    end
    mag  = (q2 >= k2) ? q2 - k2 : k2 - q2;
    m_b  = BmW'(mag) * BmW'(mag);
    case (curve)
      CurveLinear: f_comb = (FRAC_BITS+2)'(p);
      CurveIn:     f_comb = (FRAC_BITS+2)'(m_in >> FRAC_BITS);
      CurveOut:    f_comb = (FRAC_BITS+2)'(m_out >> FRAC_BITS);
      CurveInOut:  f_comb = ((p << 1) < One) ? (FRAC_BITS+2)'(m_io1 >> FRAC_BITS)
                         : (FRAC_BITS+2)'((MulW'(One) + (m_io2 >> FRAC_BITS)) >> 1);
      CurveBounce: f_comb = (FRAC_BITS+2)'((m_b >> (FRAC_BITS + 6)) + BmW'(c));
      default:     f_comb = '0;
    endcase
  end

  // Scaling: base + floor(increment * f / ONE), saturate
  localparam int ProdW = ValueW + FRAC_BITS + 2;
  logic signed [ProdW-1:0] prod;
  logic signed [ValueW+1:0] nxt, dlt;
  logic signed [ValueW-1:0] nxt_sat, dlt_sat;
  always_comb begin
    prod = ProdW'(increment) * $signed({1'b0, factor});
    nxt  = (ValueW+2)'(base_value) + (ValueW+2)'(prod >>> FRAC_BITS);
    if (nxt > (ValueW+2)'(32'sh7fffffff))       nxt_sat = 32'sh7fffffff;
    else if (nxt < -(ValueW+2)'(33'sh080000000)) nxt_sat = 32'sh80000000;
    else                                          nxt_sat = nxt[ValueW-1:0];
    dlt = (ValueW+2)'(nxt_sat) - (ValueW+2)'(cur);
    if (dlt > (ValueW+2)'(32'sh7fffffff))       dlt_sat = 32'sh7fffffff;
    else if (dlt < -(ValueW+2)'(33'sh080000000)) dlt_sat = 32'sh80000000;
    else                                          dlt_sat = dlt[ValueW-1:0];
  end

  // Control-side state
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed  <= '0;
      active   <= 1'b0;
      cur      <= '0;
      ldelta   <= '0;
      finished <= 1'b0;
      hold     <= 1'b0;
      cnt      <= '0;
    end else begin
      if (cmd.start) begin
        elapsed <= '0;
        active  <= 1'b1;
        cur     <= base_value;
      end
      if (cmd.tick) begin
        elapsed  <= el_new;
        finished <= past_end;
        hold     <= !past_end && curve > CurveBounce;
        if (past_end) active <= 1'b0;
        if (!past_end && curve > CurveBounce) ldelta <= '0;
        cnt <= CntW'(NumW);
      end else if (cmd.div_step) begin
        cnt <= cnt - 1'b1;
      end
      if (cmd.scale) begin
        cur    <= nxt_sat;
        ldelta <= dlt_sat;
      end
    end
  end

  // Divider and factor payload registers
  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      quo <= {el_new, {FRAC_BITS{1'b0}}};
      rem <= '0;
    end else if (cmd.div_step) begin
      if (!trial[IntervalW+1]) begin
        rem <= trial[IntervalW:0];
        quo <= {quo[NumW-2:0], 1'b1};
      end else begin
        rem <= {rem[IntervalW-1:0], quo[NumW-1]};
        quo <= {quo[NumW-2:0], 1'b0};
      end
    end
    if (cmd.shape) factor <= f_comb[FRAC_BITS:0];
  end

  assign stat.div_done = (cnt == '0);
  assign stat.finished = finished;
  assign stat.hold     = hold;
  assign value         = cur;
  assign delta_value   = ldelta;

  a_start_active: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> active && elapsed == '0) else $error("start did not arm");
  a_end_holds: assert property (@(posedge clk) disable iff (rst)
    cmd.tick && past_end |=> !active && $stable(cur)) else $error("end changed value");
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    cmd.shape |-> p <= One) else $error("phase above one");

endmodule

// ===== dv/eca_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// eca_checker: result predictor and scoreboard for the easing curve animator
// Follows register writes and accepted input beats, computes the expected
// value, delta and running flag, and compares every output beat in order.
// ============================================================================
module eca_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic        m_tuser,
  output int          fail_count,
  output int          pending
);
  import eca_pkg::*;

  localparam int F = FracBitsDefault;
  localparam longint ONE = 64'd1 << F;

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] delta;
    logic        running;
  } tween_out_t;

  // Shadow registers and tween state
  logic [31:0] base_q, incr_q;
  logic [15:0] intvl_q;
  logic [2:0]  curve_q;
  longint      elapsed_q, value_q, delta_q;
  bit          running_q;
  tween_out_t  tween_q[$];

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint bounce_shape(longint p);
    longint q2, k2, c, m;
    q2 = p * 22;
    if (q2 < 8 * ONE) begin
      k2 = 0; c = 0;
    end else if (q2 < 16 * ONE) begin
      k2 = 12 * ONE; c = (3 * ONE) >> 2;
    end else if (q2 < 20 * ONE) begin
      k2 = 18 * ONE; c = (15 * ONE) >> 4;
    end else begin
      k2 = 21 * ONE; c = (63 * ONE) >> 6;
    end
    m = (q2 >= k2) ? q2 - k2 : k2 - q2;
    return ((m * m) >>> (F + 6)) + c;
  endfunction

  // Advance time by one tick and update value/delta
  task automatic tick_tween(longint dt);
    longint p, f, u, nxt, prod;
    elapsed_q = elapsed_q + dt;
    if (elapsed_q > 131071) elapsed_q = 131071;
    if (elapsed_q > intvl_q) begin
      running_q = 0;
      return;
    end
    p = (intvl_q == 0) ? ONE : (elapsed_q << F) / intvl_q;
    case (curve_q)
      CurveLinear: f = p;
      CurveIn:     f = (p * p) >> F;
      CurveOut:    f = (p * (2 * ONE - p)) >> F;
      CurveInOut: begin
        if (2 * p < ONE) f = (2 * p * p) >> F;
        else begin
          u = 2 * p - ONE;
          f = (ONE + ((u * (2 * ONE - u)) >> F)) >> 1;
        end
      end
      CurveBounce: f = bounce_shape(p);
      default: begin
        delta_q = 0;
        return;
      end
    endcase
    prod = longint'(signed'(incr_q)) * f;
    nxt = clamp32(longint'(signed'(base_q)) + (prod >>> F));
    delta_q = clamp32(nxt - value_q);
    value_q = nxt;
  endtask

  always @(posedge clk) begin
    tween_out_t got, want;
    int errs;
    errs = 0;
    if (rst) begin
      base_q <= '0; incr_q <= '0; intvl_q <= 16'd1; curve_q <= CurveLinear;
      elapsed_q = 0; value_q = 0; delta_q = 0; running_q = 0;
      tween_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      // Register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          RegBase:  base_q  <= pwdata;
          RegIncr:  incr_q  <= pwdata;
          RegIntvl: intvl_q <= pwdata[15:0];
          RegCurve: curve_q <= pwdata[2:0];
          default: ;
        endcase
      end
      // Input beat
      if (s_tvalid && s_tready) begin
        if (s_tuser) begin
          elapsed_q = 0; running_q = 1; value_q = longint'(signed'(base_q));
        end else if (running_q) begin
          tick_tween(s_tdata);
        end
        tween_q.push_back('{value_q[31:0], delta_q[31:0], running_q});
      end
      // Output beat
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[31:0], m_tdata[63:32], m_tuser};
        if (tween_q.size() == 0) begin
          $error("unexpected output beat: value %h", got.value);
          errs++;
        end else begin
          want = tween_q.pop_front();
          if (got.value !== want.value) begin
            $error("value: expected %h, got %h", want.value, got.value);
            errs++;
          end
          if (got.delta !== want.delta) begin
            $error("delta_value: expected %h, got %h", want.delta, got.delta);
            errs++;
          end
          if (got.running !== want.running) begin
            $error("running: expected %b, got %b", want.running, got.running);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending <= tween_q.size();
    end
  end

endmodule

// ===== dv/tb_easing_curve_animator.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_easing_curve_animator: stimulus and verdict for the easing curve animator
// Programs several curve settings over APB, sends start/tick beats with
// random gaps and output stalls, and relies on eca_checker for comparison.
// ============================================================================
module tb_easing_curve_animator;
  import eca_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 0, s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = 0;
  logic        m_tvalid, m_tready = 0;
  logic [63:0] m_tdata;
  logic        m_tuser;
  int          fail_count, pending;
  int          send_idle = 0, sink_stall = 0;
  int          quiet_cycles = 0;

  always #10 clk = ~clk;

  easing_curve_animator dut (.*);

  eca_checker chk (.*);

  // Output stall pattern
  always @(posedge clk) m_tready <= ($urandom_range(99) >= sink_stall);

  // Watchdog on lack of progress
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // Valid drops for one cycle after each beat; the block is busy then anyway
  task automatic send_beat(bit start, logic [15:0] dt);
    while ($urandom_range(99) < send_idle) @(posedge clk);
    s_tvalid <= 1; s_tuser <= start; s_tdata <= dt;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    s_tvalid <= 0;
    @(posedge clk);
  endtask

  task automatic drain;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic program_regs(logic [31:0] b, logic [31:0] inc, logic [15:0] iv,
                              logic [2:0] cv);
    drain();
    write_reg(RegBase, b);
    write_reg(RegIncr, inc);
    write_reg(RegIntvl, iv);
    write_reg(RegCurve, cv);
  endtask

  // One animation: start then a given number of beats, mostly ticks with an occasional restart
  task automatic run_tween(int max_ticks, int dt_max);
    send_beat(1, 16'($urandom));
    for (int i = 0; i < max_ticks; i++)
      send_beat($urandom_range(15) == 0, 16'($urandom_range(dt_max)));
  endtask

  initial begin
    int items;
    int nt;
    logic [15:0] iv;
    repeat (2) @(posedge clk);
    rst <= 0;

    // Directed: idle tick, each curve, extremes, zero interval, saturation
    send_beat(0, 16'hFFFF);
    for (int c = 0; c < 8; c++) begin
      program_regs(32'h0001_0000, 32'h0064_0000, 16'd16, 3'(c));
      send_beat(1, 16'h0);
      send_beat(0, 16'd4); send_beat(0, 16'd6); send_beat(0, 16'd6);
      send_beat(0, 16'd1);
    end
    program_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, CurveLinear);
    send_beat(1, 16'd0); send_beat(0, 16'hFFFF); send_beat(0, 16'hFFFF);
    program_regs(32'h8000_0000, 32'h8000_0000, 16'd0, CurveBounce);
    send_beat(1, 16'd0); send_beat(0, 16'd0); send_beat(0, 16'd1);
    program_regs(32'h0, 32'h8000_0000, 16'd1, CurveIn);
    send_beat(1, 16'd0); send_beat(0, 16'd1);

    // Random phases with different gap and stall pressure
    items = 0;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1 || ph == 3) ? ((ph == 3) ? 37 : 75) : 0;
      sink_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 37 : 75) : 0;
      while (items < (ph + 1) * 450) begin
        iv = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 64));
        program_regs($urandom, $urandom, iv, 3'($urandom_range(7)));
        nt = $urandom_range(4, 24);
        run_tween(nt, (iv > 8) ? iv / 4 : 16);
        items += nt + 1;
      end
    end

    send_idle = 0; sink_stall = 0;
    drain();
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
src/eca_pkg.sv
src/eca_ctrl.sv
src/eca_dp.sv
src/easing_curve_animator.sv
dv/eca_checker.sv
dv/tb_easing_curve_animator.sv
